// File: rtl/assert_macros.svh
// Assertion macros used by the lexer RTL (the output queue pl0lex_out).
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/pl0lex_pkg.sv
// Package for the PL/0 lexer: constants, types, keyword match function.
// Depends on nothing.
`default_nettype none
package pl0lex_pkg;
    localparam int MaxIdent = 40;
    localparam int PosBits = 16;
    localparam int KwDepth = 9;
    localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_IDENT = 4'd2;
    localparam logic [3:0] M_NUMBER = 4'd3;
    localparam logic [3:0] M_COLON = 4'd4;
    localparam logic [3:0] M_LESS = 4'd5;
    localparam logic [3:0] M_GREATER = 4'd6;
    localparam logic [3:0] M_DONE = 4'd7;
    localparam logic [3:0] M_HALTED = 4'd8;

    localparam logic [5:0] K_EOF = 6'd0;
    localparam logic [5:0] K_IDENT = 6'd1;
    localparam logic [5:0] K_NUMBER = 6'd2;
    localparam logic [5:0] K_KW0 = 6'd3;
    localparam logic [5:0] K_BECOMES = 6'd17;
    localparam logic [5:0] K_NEQ = 6'd18;
    localparam logic [5:0] K_LEQ = 6'd19;
    localparam logic [5:0] K_GEQ = 6'd20;
    localparam logic [5:0] K_LT = 6'd21;
    localparam logic [5:0] K_GT = 6'd22;
    localparam logic [5:0] K_EQ = 6'd23;
    localparam logic [5:0] K_SEMI = 6'd24;
    localparam logic [5:0] K_PERIOD = 6'd25;
    localparam logic [5:0] K_COMMA = 6'd26;
    localparam logic [5:0] K_LPAREN = 6'd27;
    localparam logic [5:0] K_RPAREN = 6'd28;
    localparam logic [5:0] K_PLUS = 6'd29;
    localparam logic [5:0] K_MINUS = 6'd30;
    localparam logic [5:0] K_SLASH = 6'd31;
    localparam logic [5:0] K_TIMES = 6'd32;
    localparam logic [5:0] K_ERROR = 6'd33;

    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_ILLEGAL = 3'd1;
    localparam logic [2:0] E_EOF_COMMENT = 3'd2;
    localparam logic [2:0] E_IDENT_LONG = 3'd3;
    localparam logic [2:0] E_OVERFLOW = 3'd4;
    localparam logic [2:0] E_BAD_COLON = 3'd5;

    typedef logic [KwDepth-1:0][7:0] t_kw;

    typedef struct packed {
        logic [5:0] kind;
        logic [2:0] err;
        logic [14:0] value;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0] length;
    } t_tok;

    function automatic logic [71:0] kw_text(input int k);
        logic [71:0] t;
        t = '0;
        unique case (k)
            0: t[23:0] = "rav";
            1: t[15:0] = "od";
            2: t[31:0] = "piks";
            3: t[39:0] = "tsnoc";
            4: t[39:0] = "nigeb";
            5: t[31:0] = "llac";
            6: t[71:0] = "erudecorp";
            7: t[23:0] = "dne";
            8: t[39:0] = "etirw";
            9: t[31:0] = "daer";
            10: t[15:0] = "fi";
            11: t[31:0] = "neht";
            12: t[31:0] = "esle";
            default: t[23:0] = "ddo";
        endcase
        return t;
    endfunction

    function automatic int kw_len(input int k);
        int l;
        unique case (k)
            1, 10: l = 2;
            0, 7, 13: l = 3;
            2, 5, 9, 11, 12: l = 4;
            3, 4, 8: l = 5;
            default: l = 9;
        endcase
        return l;
    endfunction

    function automatic logic [5:0] ident_kind(input t_kw ch, input logic [7:0] len);
        logic [5:0] r;
        logic same;
        logic [71:0] t;
        r = K_IDENT;
        for (int k = 0; k < 14; k++) begin
            t = kw_text(k);
            same = (len == 8'(kw_len(k)));
            for (int i = 0; i < KwDepth; i++) begin
                if (i < kw_len(k) && ch[i] != t[8*i +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                r = K_KW0 + 6'(k);
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/pl0_lexer_tokenizer.sv
// PL/0 lexer top level: scanner plus result buffer.
// Depends on pl0lex_pkg, pl0lex_scan, pl0lex_out.
//
// Input channel: one request per character (i_in_char) or an end-of-file mark
// (i_end_of_file), with i_in_valid / o_in_ready.
// Output channel: one token per request on o_out_valid / i_out_ready; each
// input causes zero, one or two tokens, o_last_result marks the last one.
// A token is written to the buffer when the character that closes it is accepted.
// Throughput: one character per cycle while o_in_ready is high; a character that
// closes a pending token and emits another gives two tokens, one per output handshake.
// The scanner state registers update at the edge that accepts the character;
// its tokens go into a three-entry buffer at that same edge.
// Input is accepted while the buffer holds at most one token, so o_in_ready
// comes from the buffer count only; a stalled receiver stops input once two
// or more tokens wait.
// Reset: scanner goes idle at line 1, column 0; buffer empties.
// After end of file or an error, inputs are accepted and dropped until reset.
`default_nettype none
module pl0_lexer_tokenizer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic o_in_ready,
    input  wire logic [7:0] i_in_char,
    input  wire logic i_end_of_file,
    output logic o_out_valid,
    input  wire logic i_out_ready,
    output logic [5:0] o_token_kind,
    output logic [2:0] o_error_code,
    output logic [14:0] o_number_value,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [7:0] o_ident_length,
    output logic o_last_result
);
    logic step, space;
    logic [1:0] cnt;
    pl0lex_pkg::t_tok tok0, tok1, tok;

    assign o_in_ready = space;
    assign step = i_in_valid && space;

    pl0lex_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_c(i_in_char), .i_eof(i_end_of_file),
        .o_cnt(cnt), .o_tok0(tok0), .o_tok1(tok1)
    );

    pl0lex_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(step && cnt != 2'd0), .i_cnt(cnt),
        .i_tok0(tok0), .i_tok1(tok1), .o_space(space),
        .i_ready(i_out_ready), .o_valid(o_out_valid), .o_tok(tok), .o_last(o_last_result)
    );

    assign o_token_kind = tok.kind;
    assign o_error_code = tok.err;
    assign o_number_value = tok.value;
    assign o_token_line = tok.line;
    assign o_token_column = tok.column;
    assign o_ident_length = tok.length;
endmodule
`default_nettype wire

// File: rtl/pl0lex_out.sv
// Output queue for the lexer: three-entry result buffer with valid/ready.
// Depends on pl0lex_pkg.
`default_nettype none
`include "assert_macros.svh"
module pl0lex_out (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire logic [1:0] i_cnt,
    input  pl0lex_pkg::t_tok i_tok0,
    input  pl0lex_pkg::t_tok i_tok1,
    output logic o_space,
    input  wire logic i_ready,
    output logic o_valid,
    output pl0lex_pkg::t_tok o_tok,
    output logic o_last
);
    pl0lex_pkg::t_tok r_q [3];
    logic [2:0] r_last, n_last;
    logic [1:0] r_cnt, n_cnt;
    logic pop;
    pl0lex_pkg::t_tok n_q [3];

    assign o_valid = (r_cnt != 2'd0);
    assign o_tok = r_q[0];
    assign o_last = r_last[0];
    assign pop = o_valid && i_ready;
    // room for a full two-token request, taken from the count alone
    assign o_space = (r_cnt <= 2'd1);

    always_comb begin
        logic [1:0] base;
        n_q = r_q;
        n_last = r_last;
        base = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_last = {1'b0, r_last[2:1]};
            base = r_cnt - 2'd1;
        end
        n_cnt = base;
        if (i_push) begin
            if (i_cnt == 2'd2) begin
                n_q[base] = i_tok0;
                n_last[base] = 1'b0;
                n_q[2'(base + 2'd1)] = i_tok1;
                n_last[2'(base + 2'd1)] = 1'b1;
            end else begin
                n_q[base] = i_tok0;
                n_last[base] = 1'b1;
            end
            n_cnt = base + i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_last <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_last <= n_last;
        end
    end

    `ASSERT_IMPL(a_no_overfill, i_clk, i_rst_n, i_push, o_space)
    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3 || r_last[2])
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
endmodule
`default_nettype wire

// File: rtl/pl0lex_scan.sv
// Scanner state machine: one character per cycle while i_step is high, produces up to two tokens.
// Depends on pl0lex_pkg.
`default_nettype none
module pl0lex_scan (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic [7:0] i_c,
    input  wire logic i_eof,
    output logic [1:0] o_cnt,
    output pl0lex_pkg::t_tok o_tok0,
    output pl0lex_pkg::t_tok o_tok1
);
    localparam int PB = pl0lex_pkg::PosBits;
    logic [3:0] r_mode, n_mode;
    pl0lex_pkg::t_kw r_kw, n_kw;
    logic [7:0] r_len, n_len;
    logic [14:0] r_acc, n_acc;
    logic [PB-1:0] r_line, n_line, r_col, n_col, r_sl, n_sl, r_sc, n_sc;

    logic [PB-1:0] col;
    logic ws, let_c, dig;
    logic [18:0] v;

    always_comb begin
        pl0lex_pkg::t_tok t;
        logic start;
        col = (r_col == pl0lex_pkg::PosMax) ? r_col : r_col + 1'b1;
        ws = (i_c == 8'd32) || (i_c >= 8'd9 && i_c <= 8'd13);
        let_c = (i_c >= "A" && i_c <= "Z") || (i_c >= "a" && i_c <= "z");
        dig = (i_c >= "0" && i_c <= "9");
        v = {r_acc, 3'b0} + {2'b0, r_acc, 1'b0} + 19'(i_c - 8'd48);
        n_mode = r_mode; n_kw = r_kw; n_len = r_len; n_acc = r_acc;
        n_line = r_line; n_col = r_col; n_sl = r_sl; n_sc = r_sc;
        o_cnt = 2'd0;
        o_tok0 = '0; o_tok1 = '0;
        t = '0;
        t.line = 16'(r_sl); t.column = 16'(r_sc);
        start = 1'b0;
        // pending token as if closed now
        priority case (r_mode)
            pl0lex_pkg::M_IDENT: begin
                t.kind = pl0lex_pkg::ident_kind(r_kw, r_len); t.length = r_len;
            end
            pl0lex_pkg::M_NUMBER: begin t.kind = pl0lex_pkg::K_NUMBER; t.value = r_acc; end
            pl0lex_pkg::M_LESS: t.kind = pl0lex_pkg::K_LT;
            default: t.kind = pl0lex_pkg::K_GT;
        endcase
        if (r_mode != pl0lex_pkg::M_DONE && r_mode != pl0lex_pkg::M_HALTED) begin
            if (i_eof) begin
                o_tok1 = '0;
                o_tok1.line = 16'(r_line); o_tok1.column = 16'(col);
                if (r_mode == pl0lex_pkg::M_COMMENT || r_mode == pl0lex_pkg::M_COLON) begin
                    o_tok0 = o_tok1;
                    o_tok0.kind = pl0lex_pkg::K_ERROR;
                    o_tok0.err = (r_mode == pl0lex_pkg::M_COMMENT) ?
                        pl0lex_pkg::E_EOF_COMMENT : pl0lex_pkg::E_BAD_COLON;
                    o_cnt = 2'd1; n_mode = pl0lex_pkg::M_HALTED;
                end else if (r_mode == pl0lex_pkg::M_IDLE) begin
                    o_tok0 = o_tok1; o_cnt = 2'd1; n_mode = pl0lex_pkg::M_DONE;
                end else begin
                    o_tok0 = t; o_cnt = 2'd2; n_mode = pl0lex_pkg::M_DONE;
                end
            end else begin
                priority case (r_mode)
                    pl0lex_pkg::M_COMMENT: if (i_c == 8'd10) n_mode = pl0lex_pkg::M_IDLE;
                    pl0lex_pkg::M_IDENT: begin
                        if (let_c || dig) begin
                            if (r_len >= 8'(pl0lex_pkg::MaxIdent)) begin
                                o_tok0 = t; o_tok0.kind = pl0lex_pkg::K_ERROR;
                                o_tok0.length = '0;
                                o_tok0.err = pl0lex_pkg::E_IDENT_LONG;
                                o_cnt = 2'd1; n_mode = pl0lex_pkg::M_HALTED;
                            end else begin
                                if (r_len < 8'(pl0lex_pkg::KwDepth))
                                    n_kw[r_len[3:0]] = i_c;
                                n_len = r_len + 8'd1;
                            end
                        end else start = 1'b1;
                    end
                    pl0lex_pkg::M_NUMBER: begin
                        if (dig) begin
                            if (v > 19'd32767) begin
                                o_tok0 = t; o_tok0.kind = pl0lex_pkg::K_ERROR;
                                o_tok0.value = '0;
                                o_tok0.err = pl0lex_pkg::E_OVERFLOW;
                                o_cnt = 2'd1; n_mode = pl0lex_pkg::M_HALTED;
                            end else n_acc = v[14:0];
                        end else start = 1'b1;
                    end
                    pl0lex_pkg::M_COLON: begin
                        o_tok0 = t; o_cnt = 2'd1;
                        if (i_c == "=") begin
                            o_tok0.kind = pl0lex_pkg::K_BECOMES; n_mode = pl0lex_pkg::M_IDLE;
                        end else begin
                            o_tok0.kind = pl0lex_pkg::K_ERROR;
                            o_tok0.err = pl0lex_pkg::E_BAD_COLON;
                            o_tok0.line = 16'(r_line); o_tok0.column = 16'(col);
                            n_mode = pl0lex_pkg::M_HALTED;
                        end
                    end
                    pl0lex_pkg::M_LESS: begin
                        if (i_c == ">" || i_c == "=") begin
                            o_tok0 = t; o_cnt = 2'd1; n_mode = pl0lex_pkg::M_IDLE;
                            o_tok0.kind = (i_c == ">") ? pl0lex_pkg::K_NEQ : pl0lex_pkg::K_LEQ;
                        end else start = 1'b1;
                    end
                    pl0lex_pkg::M_GREATER: begin
                        if (i_c == "=") begin
                            o_tok0 = t; o_cnt = 2'd1; n_mode = pl0lex_pkg::M_IDLE;
                            o_tok0.kind = pl0lex_pkg::K_GEQ;
                        end else start = 1'b1;
                    end
                    default: start = 1'b1;
                endcase
                if (start) begin
                    pl0lex_pkg::t_tok s;
                    logic emit;
                    if (r_mode != pl0lex_pkg::M_IDLE) begin
                        o_tok0 = t; o_cnt = 2'd1;
                    end
                    n_mode = pl0lex_pkg::M_IDLE;
                    n_sl = r_line; n_sc = col;
                    s = '0; s.line = 16'(r_line); s.column = 16'(col);
                    emit = 1'b1;
                    if (ws) emit = 1'b0;
                    else if (i_c == "#") begin emit = 1'b0; n_mode = pl0lex_pkg::M_COMMENT; end
                    else if (let_c) begin
                        emit = 1'b0; n_mode = pl0lex_pkg::M_IDENT; n_kw[0] = i_c; n_len = 8'd1;
                    end else if (dig) begin
                        emit = 1'b0; n_mode = pl0lex_pkg::M_NUMBER; n_acc = 15'(i_c - 8'd48);
                    end else begin
                        unique case (i_c)
                            ":": begin emit = 1'b0; n_mode = pl0lex_pkg::M_COLON; end
                            "<": begin emit = 1'b0; n_mode = pl0lex_pkg::M_LESS; end
                            ">": begin emit = 1'b0; n_mode = pl0lex_pkg::M_GREATER; end
                            "=": s.kind = pl0lex_pkg::K_EQ;
                            ";": s.kind = pl0lex_pkg::K_SEMI;
                            ".": s.kind = pl0lex_pkg::K_PERIOD;
                            ",": s.kind = pl0lex_pkg::K_COMMA;
                            "(": s.kind = pl0lex_pkg::K_LPAREN;
                            ")": s.kind = pl0lex_pkg::K_RPAREN;
                            "+": s.kind = pl0lex_pkg::K_PLUS;
                            "-": s.kind = pl0lex_pkg::K_MINUS;
                            "/": s.kind = pl0lex_pkg::K_SLASH;
                            "*": s.kind = pl0lex_pkg::K_TIMES;
                            default: begin
                                s.kind = pl0lex_pkg::K_ERROR;
                                s.err = pl0lex_pkg::E_ILLEGAL;
                                n_mode = pl0lex_pkg::M_HALTED;
                            end
                        endcase
                    end
                    if (emit) begin
                        if (r_mode != pl0lex_pkg::M_IDLE) begin
                            o_tok1 = s; o_cnt = 2'd2;
                        end else begin
                            o_tok0 = s; o_cnt = 2'd1;
                        end
                    end
                end
                if (i_c == 8'd10) begin
                    n_line = (r_line == pl0lex_pkg::PosMax) ? r_line : r_line + 1'b1;
                    n_col = '0;
                end else n_col = col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) r_kw <= n_kw;
        if (!i_rst_n) begin
            r_mode <= pl0lex_pkg::M_IDLE; r_len <= '0; r_acc <= '0;
            r_line <= PB'(1); r_col <= '0; r_sl <= PB'(1); r_sc <= '0;
        end else if (i_step) begin
            r_mode <= n_mode; r_len <= n_len; r_acc <= n_acc;
            r_line <= n_line; r_col <= n_col; r_sl <= n_sl; r_sc <= n_sc;
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_pl0_lexer_tokenizer.sv
// Self-checking testbench for the PL/0 lexer: directed table, then random programs.
// Tokens are predicted per accepted request and compared in order at the output.
// Depends on pl0lex_pkg and pl0_lexer_tokenizer.
module tb_pl0_lexer_tokenizer;
    localparam int NumItems = 850;
    localparam int StallMax = 6;
    localparam int IdleLimit = 4000;
    localparam int DrainCycles = 20;

    typedef struct packed {
        logic [5:0] kind;
        logic [2:0] err;
        logic [14:0] value;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0] length;
        logic last;
    } t_exp_tok;

    typedef struct {
        logic [7:0] c;
        logic eof;
        bit chk;
        logic [5:0] kind;
    } t_req;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [7:0] i_in_char;
    logic i_end_of_file;
    logic o_out_valid;
    logic i_out_ready;
    logic [5:0] o_token_kind;
    logic [2:0] o_error_code;
    logic [14:0] o_number_value;
    logic [15:0] o_token_line;
    logic [15:0] o_token_column;
    logic [7:0] o_ident_length;
    logic o_last_result;

    pl0_lexer_tokenizer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_in_char(i_in_char), .i_end_of_file(i_end_of_file),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_token_kind(o_token_kind), .o_error_code(o_error_code),
        .o_number_value(o_number_value), .o_token_line(o_token_line),
        .o_token_column(o_token_column), .o_ident_length(o_ident_length),
        .o_last_result(o_last_result)
    );

    t_req requests[$];
    t_exp_tok expected_tokens[$];
    int errors = 0;
    int tokens_checked = 0;
    int accepted = 0;
    int idle_cycles = 0;
    int ending = 0;
    bit no_idle = 0;

    string kw_names[14] = '{"var", "do", "skip", "const", "begin", "call", "procedure",
                            "end", "write", "read", "if", "then", "else", "odd"};

    // lexer shadow state
    logic [3:0] mode;
    logic [7:0] kw_chars[pl0lex_pkg::KwDepth];
    int tok_len;
    int acc;
    int line_no, col_no, start_ln, start_col;
    int step_count;
    logic [5:0] step_kind;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] c);
        case (c)
            "=": return pl0lex_pkg::K_EQ;
            ";": return pl0lex_pkg::K_SEMI;
            ".": return pl0lex_pkg::K_PERIOD;
            ",": return pl0lex_pkg::K_COMMA;
            "(": return pl0lex_pkg::K_LPAREN;
            ")": return pl0lex_pkg::K_RPAREN;
            "+": return pl0lex_pkg::K_PLUS;
            "-": return pl0lex_pkg::K_MINUS;
            "/": return pl0lex_pkg::K_SLASH;
            "*": return pl0lex_pkg::K_TIMES;
            default: return pl0lex_pkg::K_ERROR;
        endcase
    endfunction

    function automatic bit is_source_char(logic [7:0] c);
        return is_letter(c) || is_digit(c) || is_space(c) || c == "#" || c == ":" ||
               c == "<" || c == ">" || op_kind(c) != pl0lex_pkg::K_ERROR;
    endfunction

    function automatic int sat_inc(int v);
        return (v >= int'(pl0lex_pkg::PosMax)) ? int'(pl0lex_pkg::PosMax) : v + 1;
    endfunction

    function automatic void push_tok(logic [5:0] kind, logic [2:0] err, int val,
                                     int ln, int col, int len);
        t_exp_tok t;
        t.kind = kind;
        t.err = err;
        t.value = 15'(val);
        t.line = 16'(ln);
        t.column = 16'(col);
        t.length = 8'(len);
        t.last = 1'b0;
        expected_tokens.push_back(t);
        step_count++;
        step_kind = kind;
    endfunction

    function automatic void halt_with(logic [2:0] err, int ln, int col);
        push_tok(pl0lex_pkg::K_ERROR, err, 0, ln, col, 0);
        mode = pl0lex_pkg::M_HALTED;
    endfunction

    function automatic logic [5:0] word_kind();
        bit same;
        if (tok_len > pl0lex_pkg::KwDepth) return pl0lex_pkg::K_IDENT;
        for (int k = 0; k < 14; k++) begin
            same = (kw_names[k].len() == tok_len);
            for (int i = 0; i < tok_len && same; i++)
                if (kw_names[k][i] != kw_chars[i]) same = 0;
            if (same) return pl0lex_pkg::K_KW0 + 6'(k);
        end
        return pl0lex_pkg::K_IDENT;
    endfunction

    function automatic void close_pending();
        case (mode)
            pl0lex_pkg::M_IDENT:
                push_tok(word_kind(), pl0lex_pkg::E_NONE, 0, start_ln, start_col, tok_len);
            pl0lex_pkg::M_NUMBER:
                push_tok(pl0lex_pkg::K_NUMBER, pl0lex_pkg::E_NONE, acc, start_ln, start_col, 0);
            pl0lex_pkg::M_LESS:
                push_tok(pl0lex_pkg::K_LT, pl0lex_pkg::E_NONE, 0, start_ln, start_col, 0);
            pl0lex_pkg::M_GREATER:
                push_tok(pl0lex_pkg::K_GT, pl0lex_pkg::E_NONE, 0, start_ln, start_col, 0);
            default: ;
        endcase
        mode = pl0lex_pkg::M_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c, int ln, int col);
        start_ln = ln;
        start_col = col;
        if (is_space(c)) return;
        if (c == "#") mode = pl0lex_pkg::M_COMMENT;
        else if (is_letter(c)) begin
            mode = pl0lex_pkg::M_IDENT;
            kw_chars[0] = c;
            tok_len = 1;
        end else if (is_digit(c)) begin
            mode = pl0lex_pkg::M_NUMBER;
            acc = c - "0";
        end else if (c == ":") mode = pl0lex_pkg::M_COLON;
        else if (c == "<") mode = pl0lex_pkg::M_LESS;
        else if (c == ">") mode = pl0lex_pkg::M_GREATER;
        else if (op_kind(c) != pl0lex_pkg::K_ERROR)
            push_tok(op_kind(c), pl0lex_pkg::E_NONE, 0, ln, col, 0);
        else halt_with(pl0lex_pkg::E_ILLEGAL, ln, col);
    endfunction

    function automatic void lex_request(logic [7:0] c, logic eof);
        int ln, col, v;
        ln = line_no;
        col = sat_inc(col_no);
        step_count = 0;
        step_kind = pl0lex_pkg::K_ERROR;
        if (mode == pl0lex_pkg::M_DONE || mode == pl0lex_pkg::M_HALTED) return;
        if (eof) begin
            if (mode == pl0lex_pkg::M_COMMENT) halt_with(pl0lex_pkg::E_EOF_COMMENT, ln, col);
            else if (mode == pl0lex_pkg::M_COLON) halt_with(pl0lex_pkg::E_BAD_COLON, ln, col);
            else begin
                close_pending();
                push_tok(pl0lex_pkg::K_EOF, pl0lex_pkg::E_NONE, 0, ln, col, 0);
                mode = pl0lex_pkg::M_DONE;
            end
        end else begin
            case (mode)
                pl0lex_pkg::M_COMMENT: if (c == 8'd10) mode = pl0lex_pkg::M_IDLE;
                pl0lex_pkg::M_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (tok_len >= pl0lex_pkg::MaxIdent)
                            halt_with(pl0lex_pkg::E_IDENT_LONG, start_ln, start_col);
                        else begin
                            if (tok_len < pl0lex_pkg::KwDepth) kw_chars[tok_len] = c;
                            tok_len++;
                        end
                    end else begin
                        close_pending();
                        start_token(c, ln, col);
                    end
                end
                pl0lex_pkg::M_NUMBER: begin
                    if (is_digit(c)) begin
                        v = acc * 10 + (c - "0");
                        if (v > 32767) halt_with(pl0lex_pkg::E_OVERFLOW, start_ln, start_col);
                        else acc = v;
                    end else begin
                        close_pending();
                        start_token(c, ln, col);
                    end
                end
                pl0lex_pkg::M_COLON: begin
                    if (c == "=") begin
                        push_tok(pl0lex_pkg::K_BECOMES, pl0lex_pkg::E_NONE, 0,
                                 start_ln, start_col, 0);
                        mode = pl0lex_pkg::M_IDLE;
                    end else halt_with(pl0lex_pkg::E_BAD_COLON, ln, col);
                end
                pl0lex_pkg::M_LESS: begin
                    if (c == ">" || c == "=") begin
                        push_tok(c == ">" ? pl0lex_pkg::K_NEQ : pl0lex_pkg::K_LEQ,
                                 pl0lex_pkg::E_NONE, 0, start_ln, start_col, 0);
                        mode = pl0lex_pkg::M_IDLE;
                    end else begin
                        close_pending();
                        start_token(c, ln, col);
                    end
                end
                pl0lex_pkg::M_GREATER: begin
                    if (c == "=") begin
                        push_tok(pl0lex_pkg::K_GEQ, pl0lex_pkg::E_NONE, 0,
                                 start_ln, start_col, 0);
                        mode = pl0lex_pkg::M_IDLE;
                    end else begin
                        close_pending();
                        start_token(c, ln, col);
                    end
                end
                default: begin
                    mode = pl0lex_pkg::M_IDLE;
                    start_token(c, ln, col);
                end
            endcase
            if (c == 8'd10) begin
                line_no = sat_inc(line_no);
                col_no = 0;
            end else col_no = col;
        end
        if (step_count > 0) expected_tokens[$].last = 1'b1;
    endfunction

    task automatic report_line(string msg);
        errors++;
        $display("%s", msg);
    endtask

    task automatic report_mismatch(string what, t_exp_tok got, t_exp_tok want);
        report_line($sformatf({"mismatch %s: got k%0d e%0d v%0d @%0d:%0d len%0d last%0d,",
                               " want k%0d e%0d v%0d @%0d:%0d len%0d last%0d"},
                              what, got.kind, got.err, got.value, got.line, got.column,
                              got.length, got.last, want.kind, want.err, want.value,
                              want.line, want.column, want.length, want.last));
    endtask

    task automatic add_char(logic [7:0] c);
        t_req r;
        r.c = c;
        r.eof = 1'b0;
        r.chk = 0;
        r.kind = pl0lex_pkg::K_EOF;
        requests.push_back(r);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    // character that, when taken, must close a token of the given kind
    task automatic add_checked(logic [7:0] c, logic [5:0] kind);
        t_req r;
        r.c = c;
        r.eof = 1'b0;
        r.chk = 1;
        r.kind = kind;
        requests.push_back(r);
    endtask

    task automatic add_eof();
        t_req r;
        r.c = 8'($urandom_range(0, 255));
        r.eof = 1'b1;
        r.chk = 0;
        r.kind = pl0lex_pkg::K_EOF;
        requests.push_back(r);
    endtask

    function automatic string rand_word(int len);
        string s, alnum;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
        s = "";
        for (int i = 0; i < len; i++)
            s = {s, string'(alnum[$urandom_range(0, i == 0 ? 51 : 61)])};
        return s;
    endfunction

    function automatic string rand_gap();
        string ws;
        ws = " \t\n\r\v\f";
        case ($urandom_range(0, 9))
            0: return "\n";
            1: return {"#", rand_word($urandom_range(0, 6)), " x\n"};
            2: return "  ";
            default: return string'(ws[$urandom_range(0, 5)]);
        endcase
    endfunction

    task automatic add_random_token();
        string ops[19] = '{":=", "<>", "<=", ">=", "<", ">", "=", ";", ".", ",", "(", ")",
                           "+", "-", "/", "*", "<", ">", "="};
        case ($urandom_range(0, 9))
            0, 1: add_text(kw_names[$urandom_range(0, 13)]);
            2, 3: add_text(rand_word($urandom_range(0, 19) == 0 ? pl0lex_pkg::MaxIdent
                                     : $urandom_range(1, 12)));
            4, 5: begin
                case ($urandom_range(0, 5))
                    0: add_text("32767");
                    1: add_text("0");
                    default: add_text($sformatf("%0d", $urandom_range(0, 32767)));
                endcase
            end
            default: add_text(ops[$urandom_range(0, 18)]);
        endcase
        add_text(rand_gap());
    endtask

    task automatic add_ending(int which);
        logic [7:0] c;
        case (which)
            0: add_eof();
            1: begin add_text("ab"); add_eof(); end
            2: begin
                do c = 8'($urandom_range(0, 255)); while (is_source_char(c));
                add_char(c);
            end
            3: begin add_text("#xx"); add_eof(); end
            4: add_text({rand_word(pl0lex_pkg::MaxIdent), "z"});
            5: add_text("32768");
            6: add_text(":a");
            7: begin add_text(":"); add_eof(); end
            default: begin add_text("<"); add_eof(); end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_exp_tok got, want;
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no request moved for %0d cycles", IdleLimit);
                $display("FAIL pl0_lexer_tokenizer");
                $finish;
            end
            if (i_in_valid && o_in_ready) begin
                lex_request(i_in_char, i_end_of_file);
                if (accepted < requests.size() && requests[accepted].chk &&
                    step_kind !== requests[accepted].kind) begin
                    report_line($sformatf("directed row %0d: predicted kind %0d, table says %0d",
                                          accepted, step_kind, requests[accepted].kind));
                end
                accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                got = {o_token_kind, o_error_code, o_number_value, o_token_line,
                       o_token_column, o_ident_length, o_last_result};
                if (expected_tokens.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected token", got, want);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) report_mismatch("token", got, want);
                    tokens_checked++;
                end
            end
        end
    end

    initial begin
        int gap;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_char = 8'd0;
        i_end_of_file = 1'b0;
        mode = pl0lex_pkg::M_IDLE;
        tok_len = 0;
        acc = 0;
        line_no = 1;
        col_no = 0;
        start_ln = 1;
        start_col = 0;

        add_text("a");
        add_checked(":", pl0lex_pkg::K_IDENT);
        add_text("=32767");
        add_checked("<", pl0lex_pkg::K_NUMBER);
        add_checked(">", pl0lex_pkg::K_NEQ);
        add_text("<");
        add_checked("=", pl0lex_pkg::K_LEQ);
        add_text(">");
        add_checked("=", pl0lex_pkg::K_GEQ);
        add_checked("(", pl0lex_pkg::K_LPAREN);
        add_text("+-/*,.;#c\n");
        while (requests.size() < NumItems) add_random_token();
        ending = $urandom_range(0, 8);
        add_ending(ending);
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 3) == 0) add_eof();
            else add_char(8'($urandom_range(0, 255)));
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (requests[i]) begin
            if (i % 120 == 0) no_idle = ($urandom_range(0, 2) == 0);
            gap = no_idle ? 0 : $urandom_range(0, StallMax);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_char <= requests[i].c;
            i_end_of_file <= requests[i].eof;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;
        while (expected_tokens.size() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("covered %0d requests, %0d tokens checked, ending case %0d",
                 accepted, tokens_checked, ending);
        if (errors == 0) $display("PASS pl0_lexer_tokenizer");
        else $display("FAIL pl0_lexer_tokenizer");
        $finish;
    end

    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, StallMax);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/pl0lex_pkg.sv
rtl/pl0lex_out.sv
rtl/pl0lex_scan.sv
rtl/pl0_lexer_tokenizer.sv
tb/tb_pl0_lexer_tokenizer.sv
